@@ design/ir_ring_bearing_tracker_assert.svh @@
// Assertion macros for the bearing tracker.
`ifndef IR_RING_BEARING_TRACKER_ASSERT_SVH
`define IR_RING_BEARING_TRACKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IRB_ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define IRB_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define IRB_ASSERT_IMPL(label, clk, rstn, prop)
`define IRB_ASSERT_NEXT(label, clk, rstn, a, b)
`endif
`endif

@@ design/irb_pkg.sv @@
`default_nettype none
package irb_pkg;
    localparam int DegreesFull = 360;
endpackage
`default_nettype wire

@@ design/irb_ram.sv @@
`default_nettype none
module irb_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 96
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ design/irb_div.sv @@
`default_nettype none
module irb_div #(
    parameter int W = 24
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] num,
    input  wire logic [W-1:0] den,
    output logic              busy,
    output logic      [W-1:0] quo
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  q_reg, d_reg;
    logic [W:0]    r_reg;
    logic [CW-1:0] cnt_reg;
    logic [W:0]    trial;
    assign trial = {r_reg[W-1:0], q_reg[W-1]} - {1'b0, d_reg};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            q_reg   <= num;
            d_reg   <= den;
            r_reg   <= '0;
            cnt_reg <= CW'(W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (!trial[W]) begin
                r_reg <= trial;
                q_reg <= {q_reg[W-2:0], 1'b1};
            end else begin
                r_reg <= {r_reg[W-1:0], q_reg[W-1]};
                q_reg <= {q_reg[W-2:0], 1'b0};
            end
        end
    end
    assign busy = cnt_reg != '0;
    assign quo  = q_reg;
endmodule
`default_nettype wire

@@ design/ir_ring_bearing_tracker.sv @@
`default_nettype none
`include "ir_ring_bearing_tracker_assert.svh"
// Each sample is written to the next slot of a store of SENSORS*SAMPLES_PER_SENSOR
// slots (cleared after reset by one pass over every slot, during which no item is
// taken). The block then walks the whole store, one slot a cycle through the
// single read port, for the swing of each sensor, finds the strongest sensor and
// runs two serial divides. The result waits in an output register, and the next
// item is taken only once that result has been accepted.
module ir_ring_bearing_tracker
    import irb_pkg::*;
#(
    parameter int SENSORS = 12,
    parameter int SAMPLES_PER_SENSOR = 8,
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [9:0]             s_sample,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic      [3:0]             m_next_channel,
    output logic                        m_sweep_done,
    output logic      [3:0]             m_peak_eye,
    output logic      [8:0]             m_direction,
    output logic      [10:0]            m_magnitude
);
    localparam int TOTAL = SENSORS * SAMPLES_PER_SENSOR;
    localparam int AW = $clog2(TOTAL);
    localparam int EW = $clog2(SENSORS);
    localparam int KW = $clog2(SAMPLES_PER_SENSOR);
    localparam int SB = SAMPLE_BITS;
    localparam int DW = 24;
    localparam int Step = DegreesFull / SENSORS;
    localparam int Half = Step / 2;

    localparam logic [3:0] ST_CLR = 4'd0, ST_IDLE = 4'd1, ST_WALK = 4'd2,
        ST_NB = 4'd3, ST_NB2 = 4'd4, ST_D1 = 4'd5, ST_D1W = 4'd6, ST_D2 = 4'd7,
        ST_D2W = 4'd8, ST_OUT = 4'd9;

    logic [3:0]    st_reg;
    logic [AW-1:0] cnt_reg, cur_reg, ra_reg;
    logic [KW-1:0] k_reg;
    logic [EW-1:0] sen_reg, peak_reg;
    logic          wrap_reg, rv_reg;
    logic [SB-1:0] hi_reg, lo_reg;
    logic [SB-1:0] sw_reg [SENSORS];
    logic [SB-1:0] p_reg, l_reg, r_reg;
    logic [DW-1:0] q1_reg;
    logic          n1neg_reg;
    logic          we;
    logic [AW-1:0] wa;
    logic [SB-1:0] wd, rd;
    logic          dstart, dbusy;
    logic [DW-1:0] dnum, dden, dq;
    logic [EW-1:0] lft, rgt;
    logic [SB-1:0] v, swing;

    irb_ram #(.WIDTH(SB), .DEPTH(TOTAL)) u_ram (
        .aclk(aclk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra_reg), .rdata(rd));
    irb_div #(.W(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart), .num(dnum), .den(dden),
        .busy(dbusy), .quo(dq));

    assign s_ready = st_reg == ST_IDLE && !m_valid;
    assign we = st_reg == ST_CLR || (s_valid && s_ready);
    assign wa = cnt_reg;
    assign wd = st_reg == ST_CLR ? '0 : SB'(s_sample);
    assign v = rd;
    assign swing = (v > hi_reg ? v : hi_reg) - (v < lo_reg ? v : lo_reg);
    assign lft = peak_reg == '0 ? EW'(SENSORS - 1) : peak_reg - 1'b1;
    assign rgt = peak_reg == EW'(SENSORS - 1) ? '0 : peak_reg + 1'b1;

    logic [SB-1:0] mn, dnr, pl;
    logic [SB:0]   diff;
    assign mn = l_reg < r_reg ? l_reg : r_reg;
    assign diff = l_reg < r_reg ? {1'b0, r_reg - l_reg} : {1'b0, l_reg - r_reg};
    assign dnr = p_reg - mn;
    assign pl = l_reg < r_reg ? r_reg : l_reg;
    assign dstart = st_reg == ST_D1 || st_reg == ST_D2;
    always_comb begin
        if (st_reg == ST_D1) begin
            dnum = DW'(Half) * DW'(diff);
            dden = DW'(dnr);
        end else begin
            dnum = DW'(pl) * DW'(diff);
            dden = DW'(dnr);
        end
    end

    logic signed [DW+1:0] ang;
    logic [DW-1:0] q1;
    logic [DW-1:0] magsum;
    assign q1 = dnr == '0 ? '0 : q1_reg;
    always_comb begin
        ang = (DW+2)'(Step) * $signed({{(DW+2-EW){1'b0}}, peak_reg});
        ang = n1neg_reg ? ang - $signed({2'b00, q1}) : ang + $signed({2'b00, q1});
        if (ang < 0) ang = ang + (DW+2)'(DegreesFull);
        if (ang >= (DW+2)'(DegreesFull)) ang = ang - (DW+2)'(DegreesFull);
        magsum = DW'(p_reg) + (dnr == '0 ? '0 : dq);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_CLR;
            cnt_reg <= '0;
            m_valid <= 1'b0;
            rv_reg  <= 1'b0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            case (st_reg)
                ST_CLR: begin
                    if (cnt_reg == AW'(TOTAL - 1)) begin
                        cnt_reg <= '0;
                        st_reg  <= ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        wrap_reg <= cnt_reg == AW'(TOTAL - 1);
                        cnt_reg  <= cnt_reg == AW'(TOTAL - 1) ? '0 : cnt_reg + 1'b1;
                        ra_reg   <= '0;
                        rv_reg   <= 1'b0;
                        k_reg    <= '0;
                        sen_reg  <= '0;
                        peak_reg <= '0;
                        st_reg   <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    rv_reg <= ra_reg != AW'(TOTAL - 1) || !rv_reg;
                    if (ra_reg != AW'(TOTAL - 1)) ra_reg <= ra_reg + 1'b1;
                    if (rv_reg) begin
                        if (k_reg == '0) begin
                            hi_reg <= v;
                            lo_reg <= v;
                        end else begin
                            hi_reg <= v > hi_reg ? v : hi_reg;
                            lo_reg <= v < lo_reg ? v : lo_reg;
                        end
                        if (k_reg == KW'(SAMPLES_PER_SENSOR - 1)) begin
                            k_reg <= '0;
                            sw_reg[sen_reg] <= swing;
                            if (sen_reg != '0 && swing > sw_reg[peak_reg])
                                peak_reg <= sen_reg;
                            if (sen_reg == EW'(SENSORS - 1)) st_reg <= ST_NB;
                            sen_reg <= sen_reg + 1'b1;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                ST_NB: begin
                    rv_reg <= 1'b0;
                    p_reg <= sw_reg[peak_reg];
                    l_reg <= sw_reg[lft];
                    r_reg <= sw_reg[rgt];
                    st_reg <= ST_D1;
                end
                ST_D1: begin
                    n1neg_reg <= !(l_reg < r_reg);
                    st_reg <= ST_D1W;
                end
                ST_D1W: if (!dbusy) begin
                    q1_reg <= dq;
                    st_reg <= ST_D2;
                end
                ST_D2: st_reg <= ST_D2W;
                ST_D2W: if (!dbusy) st_reg <= ST_OUT;
                ST_OUT: if (!m_valid) begin
                    m_valid        <= 1'b1;
                    m_next_channel <= 4'(cnt_reg / AW'(SAMPLES_PER_SENSOR));
                    m_sweep_done   <= wrap_reg;
                    m_peak_eye     <= 4'(peak_reg);
                    m_direction    <= ang[8:0];
                    m_magnitude    <= magsum[10:0];
                    st_reg         <= ST_IDLE;
                end
                default: st_reg <= ST_CLR;
            endcase
        end
    end

    // L==R: both numerators are 0; equal diff case handled by zero diff
    `IRB_ASSERT_NEXT(a_acc_walk, aclk, aresetn, s_valid && s_ready, st_reg == ST_WALK)
    `IRB_ASSERT_IMPL(a_no_in_busy, aclk, aresetn, (st_reg != ST_IDLE) |-> !s_ready)
    `IRB_ASSERT_IMPL(a_cnt_rng, aclk, aresetn, cnt_reg <= AW'(TOTAL - 1))
endmodule
`default_nettype wire
